// ===== hw/rtl/timed_serial_receiver_ring_fifo_assert.svh =====
// Assertion macros for the timed serial receiver block.
// Clocked on clk, disabled while rst_n is low; define ASSERT_OFF to drop them.
`ifndef TIMED_SERIAL_RECEIVER_RING_FIFO_ASSERT_SVH
`define TIMED_SERIAL_RECEIVER_RING_FIFO_ASSERT_SVH
`ifndef ASSERT_OFF
`define TSR_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define TSR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define TSR_ASSERT_ALWAYS(label, expr)
`define TSR_ASSERT_IMPL(label, ante, cons)
`endif
`endif

// ===== hw/rtl/tsr_pkg.sv =====
// Shared types and constants of the timed serial receiver.
// No dependencies.
`default_nettype none
package tsr_pkg;

    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_PEEK  = 2'd2;
    localparam logic [1:0] CMD_FLUSH = 2'd3;

    localparam logic [1:0] REG_RX_ENABLE  = 2'd0;
    localparam logic [1:0] REG_EDGE_POL   = 2'd1;
    localparam logic [1:0] REG_START_WAIT = 2'd2;
    localparam logic [1:0] REG_HALF_BIT   = 2'd3;

    localparam logic [7:0] START_WAIT_RESET = 8'd15;
    localparam logic [7:0] HALF_BIT_RESET   = 8'd100;
    localparam int         FRAME_BITS       = 8;

    typedef struct packed {
        logic       rx_enable;
        logic       edge_polarity;
        logic [7:0] start_wait_ticks;
        logic [7:0] half_bit_ticks;
    } cfg_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       data_valid;
        logic [4:0] fill_count;
        logic       receiving;
        logic       overrun;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t res;
    } stage_t;

endpackage
`default_nettype wire

// ===== hw/rtl/timed_serial_receiver_ring_fifo.sv =====
// Top level of the timed serial receiver with ring buffer; holds the configuration.
// Depends on tsr_pkg, tsr_front, tsr_queue and the assertion macro header.
//
// Use: every slave transfer is one tick of the line time base. s_tdata[0] is the
// line level, s_tuser carries the command (none, read and pop, peek, flush).
// Every tick gives exactly one master transfer with the read byte, fill count,
// receiving flag and overrun pulse in m_tdata and the read-hit flag in m_tuser.
// Throughput is one tick per cycle unless the output stalls: the tick is resolved by the
// frame timer and ring pointers, with the byte store read at its registered port.
// A result reaches m_tvalid through the store read register, then the result queue.
// A two-entry result queue sits between the front and the output; while the
// receiver stalls, s_tready falls once that queue and the front register are full.
// Reset clears pointers, timer and queue; the line is taken as idle (high) and the
// configuration returns to enabled, falling edge, start wait 15, half bit 100.
// The byte store is not cleared; only written entries are ever read. Configuration
// is written via cfg_we/cfg_index/cfg_wdata by the user only while idle; unchecked.
`default_nettype none
`include "timed_serial_receiver_ring_fifo_assert.svh"
module timed_serial_receiver_ring_fifo #(
    parameter int DEPTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] rx_level, [7:1] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] read_data, [12:8] fill_count,
                                        // [13] receiving, [14] overrun, [15] zero
    output logic             m_tuser    // [0] data_valid
);

    tsr_pkg::cfg_t    cfg_reg;
    tsr_pkg::stage_t  stage;
    tsr_pkg::result_t res;
    logic             stage_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rx_enable        <= 1'b1;
            cfg_reg.edge_polarity    <= 1'b0;
            cfg_reg.start_wait_ticks <= tsr_pkg::START_WAIT_RESET;
            cfg_reg.half_bit_ticks   <= tsr_pkg::HALF_BIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tsr_pkg::REG_RX_ENABLE:  cfg_reg.rx_enable        <= cfg_wdata[0];
                tsr_pkg::REG_EDGE_POL:   cfg_reg.edge_polarity    <= cfg_wdata[0];
                tsr_pkg::REG_START_WAIT: cfg_reg.start_wait_ticks <= cfg_wdata;
                tsr_pkg::REG_HALF_BIT:   cfg_reg.half_bit_ticks   <= cfg_wdata;
                default:                 cfg_reg <= cfg_reg;
            endcase
        end
    end

    tsr_front #(
        .DEPTH(DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .rx_level   (s_tdata[0]),
        .cmd        (s_tuser),
        .stage      (stage),
        .stage_ready(stage_ready)
    );

    tsr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .stage      (stage),
        .stage_ready(stage_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (res)
    );

    assign m_tdata = {1'b0, res.overrun, res.receiving, res.fill_count, res.read_data};
    assign m_tuser = res.data_valid;

    `TSR_ASSERT_IMPL(a_miss_reads_zero, m_tvalid && !m_tuser, m_tdata[7:0] == 8'd0)
    `TSR_ASSERT_IMPL(a_stall_has_output, !s_tready, m_tvalid)
    `TSR_ASSERT_IMPL(a_overrun_ends_frame, m_tvalid && m_tdata[14], !m_tdata[13])

endmodule
`default_nettype wire

// ===== hw/rtl/tsr_front.sv =====
// Front part: frame timing, ring buffer pointers and byte store, one tick per cycle unless stalled.
// Depends on tsr_pkg; hands one result per tick to the result queue.
`default_nettype none
module tsr_front #(
    parameter int DEPTH = 32
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire tsr_pkg::cfg_t   cfg,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic            rx_level,
    input  wire logic [1:0]      cmd,
    output tsr_pkg::stage_t      stage,
    input  wire logic            stage_ready
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CW    = PTR_W + 1;
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    typedef enum logic [1:0] {PH_IDLE, PH_START, PH_FIRST, PH_SECOND} phase_t;

    logic [7:0]       mem [DEPTH];
    logic [7:0]       mem_q_reg;
    logic [PTR_W-1:0] wp_reg, wp_next, rp_reg, rp_next, wp_c;
    logic             prev_reg;
    phase_t           phase_reg, phase_next;
    logic [7:0]       tc_reg, tc_next;
    logic [2:0]       bit_reg, bit_next;
    logic [7:0]       shift_reg, shift_next;
    logic             drop_reg, drop_next;
    logic             a_valid_reg, hit_reg;
    logic [4:0]       fill_reg;
    logic             recv_reg, ovr_reg;
    logic             accept, hit, nonempty, full_c, edge_seen, tc_done, commit, ovr;
    logic [CW-1:0]    cnt;
    logic [CW+4:0]    cnt_wide;

    function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    assign accept   = in_valid && in_ready;
    assign in_ready = !a_valid_reg || stage_ready;
    assign nonempty = wp_reg != rp_reg;
    assign hit      = (cmd == tsr_pkg::CMD_READ || cmd == tsr_pkg::CMD_PEEK) && nonempty;
    assign tc_done  = tc_reg <= 8'd1;
    assign edge_seen = cfg.edge_polarity ? (!prev_reg && rx_level) : (prev_reg && !rx_level);

    always_comb
    begin
        wp_c = wp_reg;
        rp_next = rp_reg;
        if (cmd == tsr_pkg::CMD_FLUSH)
        begin
            wp_c = '0;
            rp_next = '0;
        end
        else if (cmd == tsr_pkg::CMD_READ && nonempty)
        begin
            rp_next = inc(rp_reg);
        end
    end

    assign full_c = inc(wp_c) == rp_next;

    always_comb
    begin
        phase_next = phase_reg;
        tc_next    = tc_done ? tc_reg : tc_reg - 8'd1;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        drop_next  = drop_reg;
        commit     = 1'b0;
        ovr        = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                tc_next = tc_reg;
                if (cfg.rx_enable && edge_seen)
                begin
                    drop_next  = full_c;
                    shift_next = '0;
                    bit_next   = '0;
                    if (cfg.start_wait_ticks == 8'd0)
                    begin
                        phase_next = PH_FIRST;
                        tc_next    = cfg.half_bit_ticks;
                    end
                    else
                    begin
                        phase_next = PH_START;
                        tc_next    = cfg.start_wait_ticks;
                    end
                end
            end
            PH_START:
            begin
                if (tc_done)
                begin
                    phase_next = PH_FIRST;
                    tc_next    = cfg.half_bit_ticks;
                end
            end
            PH_FIRST:
            begin
                if (tc_done)
                begin
                    shift_next[bit_reg] = !rx_level;
                    phase_next = PH_SECOND;
                    tc_next    = cfg.half_bit_ticks;
                end
            end
            PH_SECOND:
            begin
                if (tc_done)
                begin
                    if (bit_reg == 3'(tsr_pkg::FRAME_BITS - 1))
                    begin
                        ovr        = drop_reg || full_c;
                        commit     = !(drop_reg || full_c);
                        phase_next = PH_IDLE;
                        tc_next    = '0;
                        bit_next   = '0;
                        drop_next  = 1'b0;
                    end
                    else
                    begin
                        bit_next   = bit_reg + 3'd1;
                        phase_next = PH_FIRST;
                        tc_next    = cfg.half_bit_ticks;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    assign wp_next  = commit ? inc(wp_c) : wp_c;
    assign cnt      = (wp_next >= rp_next) ? {1'b0, wp_next} - {1'b0, rp_next}
                                           : {1'b0, wp_next} + CW'(DEPTH) - {1'b0, rp_next};
    assign cnt_wide = {5'b0, cnt};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem_q_reg <= mem[rp_reg];
            if (commit)
            begin
                mem[wp_c] <= shift_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            rp_reg      <= '0;
            prev_reg    <= 1'b1;
            phase_reg   <= PH_IDLE;
            tc_reg      <= '0;
            bit_reg     <= '0;
            shift_reg   <= '0;
            drop_reg    <= 1'b0;
            a_valid_reg <= 1'b0;
            hit_reg     <= 1'b0;
            fill_reg    <= '0;
            recv_reg    <= 1'b0;
            ovr_reg     <= 1'b0;
        end
        else if (accept)
        begin
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            prev_reg    <= rx_level;
            phase_reg   <= phase_next;
            tc_reg      <= tc_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            drop_reg    <= drop_next;
            a_valid_reg <= 1'b1;
            hit_reg     <= hit;
            fill_reg    <= cnt_wide[4:0];
            recv_reg    <= phase_next != PH_IDLE;
            ovr_reg     <= ovr;
        end
        else if (stage_ready)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        stage.valid          = a_valid_reg;
        stage.res.read_data  = hit_reg ? mem_q_reg : 8'd0;
        stage.res.data_valid = hit_reg;
        stage.res.fill_count = fill_reg;
        stage.res.receiving  = recv_reg;
        stage.res.overrun    = ovr_reg;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/tsr_queue.sv =====
// Back part: two-entry result queue that drives the output stream.
// Depends on tsr_pkg.
`default_nettype none
module tsr_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire tsr_pkg::stage_t stage,
    output logic                 stage_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output tsr_pkg::result_t     out_res
);

    tsr_pkg::result_t q_reg [2];
    logic             wr_reg, rd_reg;
    logic [1:0]       count_reg, count_next;
    logic             push, pop;

    assign stage_ready = count_reg != 2'd2;
    assign push        = stage.valid && stage_ready;
    assign out_valid   = count_reg != 2'd0;
    assign pop         = out_valid && out_ready;
    assign out_res     = q_reg[rd_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= stage.res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire
